// ----- sv/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and helper functions shared by the infix-to-postfix
// converter modules.
// ----------------------------------------------------------------------------
package itp_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       expr_last;
    } t_item;

    typedef logic [1:0] t_status;

    localparam t_status ST_CHAR      = 2'd0;
    localparam t_status ST_UNMATCHED = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_END       = 2'd3;

    typedef struct packed {
        logic [7:0] char_out;
        t_status    status;
        logic       run_last;
    } t_result;

    typedef enum logic [1:0] {
        K_ALNUM,
        K_OPEN,
        K_CLOSE,
        K_OPER
    } t_kind;

    typedef struct packed {
        logic [7:0] ch;
        t_kind      kind;
        logic [1:0] prio;
        logic       last;
    } t_token;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALNUM,
        S_PUSH,
        S_OPER,
        S_CLOSE,
        S_FLUSH,
        S_DONE
    } t_state;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5A;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    function automatic logic [1:0] prio_of(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            CH_PLUS, CH_MINUS:        p = 2'd1;
            CH_STAR, CH_SLASH, CH_PCT: p = 2'd2;
            CH_CARET:                 p = 2'd3;
            default:                  p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) ||
               ((c >= CH_UC_LO) && (c <= CH_UC_HI)) ||
               ((c >= CH_LC_LO) && (c <= CH_LC_HI));
    endfunction

endpackage

// ----- sv/itp_ram.sv -----
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/itp_front.sv -----
// ----------------------------------------------------------------------------
// itp_front
// Input side: accepts characters and classifies them into tokens (operand,
// open paren, close paren, operator with priority) for the token queue.
// ----------------------------------------------------------------------------
module itp_front import itp_pkg::*; (
    input  logic   i_valid,
    input  t_item  i_item,
    input  logic   i_q_full,
    output logic   o_stall,
    output logic   o_q_wr,
    output t_token o_tok
);

    t_kind w_kind;

    always_comb begin
        if (is_alnum(i_item.char_in)) begin
            w_kind = K_ALNUM;
        end else if (i_item.char_in == CH_OPEN) begin
            w_kind = K_OPEN;
        end else if (i_item.char_in == CH_CLOSE) begin
            w_kind = K_CLOSE;
        end else begin
            w_kind = K_OPER;
        end
    end

    assign o_stall    = i_q_full;
    assign o_q_wr     = i_valid && !i_q_full;
    assign o_tok.ch   = i_item.char_in;
    assign o_tok.kind = w_kind;
    assign o_tok.prio = prio_of(i_item.char_in);
    assign o_tok.last = i_item.expr_last;

endmodule

// ----- sv/itp_fifo.sv -----
// ----------------------------------------------------------------------------
// itp_fifo
// Two-entry token queue between the classifier and the stack engine.
// ----------------------------------------------------------------------------
module itp_fifo import itp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_token i_wdata,
    input  logic   i_rd,
    output t_token o_rdata,
    output logic   o_valid,
    output logic   o_full
);

    t_token     r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp ^ i_wr;
        n_rp  = r_rp ^ i_rd;
        n_cnt = r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

// ----- sv/itp_back.sv -----
// ----------------------------------------------------------------------------
// itp_back
// Stack engine: runs the operator stack for each token, emits postfix words
// through a one-deep pending slot (so run_last can be set on the final word)
// and an output register.
// ----------------------------------------------------------------------------
module itp_back import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tok_valid,
    input  t_token                         i_tok,
    output logic                           o_tok_pop,
    output logic                           o_valid,
    output t_result                        o_result,
    input  logic                           i_stall,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_count
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] w_cm1, w_cm2;
    logic [7:0]  r_top, n_top;
    logic [7:0]  w_rd_data;
    logic        r_rd_ok;
    logic        r_disc, n_disc;
    t_token      r_tok;
    logic        r_pend_valid, n_pend_valid;
    logic [7:0]  r_pend_char, n_pend_char;
    t_status     r_pend_status, n_pend_status;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        w_empty, w_full, w_top_ok, w_out_free, w_can_emit;
    logic        w_pop_hit, w_top_open;
    logic        w_take, w_adv, w_pop, w_push, w_emit, w_clear;
    logic        w_disc_set, w_disc_clr, w_finish, w_push_path;
    logic [7:0]  w_emit_char;
    t_status     w_emit_status;
    t_state      w_after;

    assign w_cm1      = r_count - CW'(1);
    assign w_cm2      = r_count - CW'(2);
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    // the entry below the top is readable once the RAM read was issued at the current count
    assign w_top_ok   = r_rd_ok || (r_count == CW'(1));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_can_emit = !r_pend_valid || w_out_free;
    assign w_pop_hit  = !w_empty && (prio_of(r_top) >= r_tok.prio);
    assign w_top_open = (r_top == CH_OPEN);
    assign w_after    = r_tok.last ? S_FLUSH : S_DONE;

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_push && !w_empty),
        .i_waddr (w_cm1[AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (w_cm2[AW-1:0]),
        .o_rdata (w_rd_data)
    );

    // actions of the current state
    always_comb begin
        w_take        = 1'b0;
        w_adv         = 1'b0;
        w_pop         = 1'b0;
        w_push        = 1'b0;
        w_emit        = 1'b0;
        w_clear       = 1'b0;
        w_disc_set    = 1'b0;
        w_disc_clr    = 1'b0;
        w_finish      = 1'b0;
        w_push_path   = 1'b0;
        w_emit_char   = CH_NUL;
        w_emit_status = ST_CHAR;
        case (r_state)
            S_IDLE: begin
                w_take = i_tok_valid;
            end
            S_ALNUM: begin
                if (w_can_emit) begin
                    w_emit      = 1'b1;
                    w_emit_char = r_tok.ch;
                    w_adv       = 1'b1;
                end
            end
            S_PUSH: begin
                w_push_path = 1'b1;
            end
            S_OPER: begin
                if (w_pop_hit) begin
                    if (w_can_emit && w_top_ok) begin
                        w_pop       = 1'b1;
                        w_emit      = 1'b1;
                        w_emit_char = r_top;
                    end
                end else begin
                    w_push_path = 1'b1;
                end
            end
            S_CLOSE: begin
                if (w_empty) begin
                    if (w_can_emit) begin
                        w_emit        = 1'b1;
                        w_emit_status = ST_UNMATCHED;
                        w_clear       = 1'b1;
                        w_disc_set    = 1'b1;
                        w_adv         = 1'b1;
                    end
                end else if (w_top_open) begin
                    // drop the matching open paren
                    if (w_top_ok) begin
                        w_pop = 1'b1;
                        w_adv = 1'b1;
                    end
                end else if (w_can_emit && w_top_ok) begin
                    w_pop       = 1'b1;
                    w_emit      = 1'b1;
                    w_emit_char = r_top;
                end
            end
            S_FLUSH: begin
                if (!w_empty) begin
                    if (w_can_emit && w_top_ok) begin
                        w_pop       = 1'b1;
                        w_emit      = 1'b1;
                        w_emit_char = r_top;
                    end
                end else if (w_can_emit) begin
                    w_emit        = 1'b1;
                    w_emit_status = ST_END;
                    w_disc_clr    = 1'b1;
                    w_adv         = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_pend_valid || w_out_free) begin
                    w_finish = r_pend_valid;
                    w_adv    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_push_path) begin
            if (w_full) begin
                if (w_can_emit) begin
                    w_emit        = 1'b1;
                    w_emit_status = ST_OVERFLOW;
                    w_clear       = 1'b1;
                    w_disc_set    = 1'b1;
                    w_adv         = 1'b1;
                end
            end else begin
                w_push = 1'b1;
                w_adv  = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (r_disc) begin
                        n_state = i_tok.last ? S_FLUSH : S_DONE;
                    end else begin
                        case (i_tok.kind)
                            K_ALNUM: n_state = S_ALNUM;
                            K_OPEN:  n_state = S_PUSH;
                            K_CLOSE: n_state = S_CLOSE;
                            K_OPER:  n_state = S_OPER;
                            default: n_state = S_OPER;
                        endcase
                    end
                end
            end
            S_FLUSH: begin
                if (w_adv) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_adv) begin
                    n_state = S_IDLE;
                end
            end
            S_ALNUM, S_PUSH, S_OPER, S_CLOSE: begin
                if (w_adv) begin
                    n_state = w_after;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        if (w_clear) begin
            n_count = '0;
        end else if (w_pop) begin
            n_count = w_cm1;
            n_top   = w_rd_data;
        end else if (w_push) begin
            n_count = r_count + CW'(1);
            n_top   = r_tok.ch;
        end

        n_disc = r_disc;
        if (w_disc_set) begin
            n_disc = 1'b1;
        end else if (w_disc_clr) begin
            n_disc = 1'b0;
        end

        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_finish) begin
            n_out_valid    = 1'b1;
            n_out.char_out = r_pend_char;
            n_out.status   = r_pend_status;
            n_out.run_last = 1'b1;
        end else if (w_emit && r_pend_valid) begin
            n_out_valid    = 1'b1;
            n_out.char_out = r_pend_char;
            n_out.status   = r_pend_status;
            n_out.run_last = 1'b0;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end

        n_pend_valid  = r_pend_valid;
        n_pend_char   = r_pend_char;
        n_pend_status = r_pend_status;
        if (w_emit) begin
            n_pend_valid  = 1'b1;
            n_pend_char   = w_emit_char;
            n_pend_status = w_emit_status;
        end else if (w_finish) begin
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_rd_ok      <= 1'b0;
            r_disc       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_rd_ok      <= (n_count == r_count);
            r_disc       <= n_disc;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top         <= n_top;
        r_pend_char   <= n_pend_char;
        r_pend_status <= n_pend_status;
        r_out         <= n_out;
        if (w_take) begin
            r_tok <= i_tok;
        end
    end

    assign o_tok_pop = w_take;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;
    assign o_count   = r_count;

endmodule

// ----- sv/infix_to_postfix_converter.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall / i_item): one character a word, with
// expr_last on the final character of an expression. Output channel
// (o_valid / i_stall / o_result): zero or more words per input word; the
// final word caused by an input has run_last set. Operands pass straight
// through, operators go through a stack of STACK_DEPTH entries held in a RAM
// with the top entry kept in a register. The last character flushes the
// stack and ends with an end-of-expression word (status 3). Unmatched ')'
// or a push onto a full stack gives an error word and drops input up to the
// end of the expression.
// An accepted operand goes from the token queue through the engine's pending
// slot to the output register. Each pop takes the new top from the stack
// RAM's registered read, so a pop waits until that read was issued at the
// current stack count.
// A two-word token queue lets input be taken while the engine works.
// Reset empties the stack, the queue and the output; the stack RAM is not
// cleared. When the receiver stalls, the output word holds, the engine stops
// once its pending word and the output register are full, and o_stall rises
// when the token queue fills.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter import itp_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic          w_q_wr, w_q_full, w_q_valid, w_q_rd;
    t_token        w_wr_tok, w_rd_tok;
    logic [CW-1:0] w_count;

    itp_front u_front (
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_q_full (w_q_full),
        .o_stall  (o_stall),
        .o_q_wr   (w_q_wr),
        .o_tok    (w_wr_tok)
    );

    itp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_wr_tok),
        .i_rd    (w_q_rd),
        .o_rdata (w_rd_tok),
        .o_valid (w_q_valid),
        .o_full  (w_q_full)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_q_valid),
        .i_tok       (w_rd_tok),
        .o_tok_pop   (w_q_rd),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_stall     (i_stall),
        .o_count     (w_count)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_END)) |-> o_result.run_last)
        else $error("end marker without run_last");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_rd |-> w_q_valid)
        else $error("token queue read while empty");

endmodule
